// ----- sv/japanese_encoding_guesser_macros.svh -----
// Assertion helpers used by jeg_checker.sv.
`ifndef JAPANESE_ENCODING_GUESSER_MACROS_SVH
`define JAPANESE_ENCODING_GUESSER_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define JEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define JEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/jeg_pkg.sv -----
package jeg_pkg;

  // Verdict codes
  localparam logic [2:0] VERDICT_UNKNOWN = 3'd0;
  localparam logic [2:0] VERDICT_JIS     = 3'd1;
  localparam logic [2:0] VERDICT_EUC     = 3'd2;
  localparam logic [2:0] VERDICT_SJIS    = 3'd3;
  localparam logic [2:0] VERDICT_BINARY  = 3'd4;

  // Scan mode codes
  localparam logic [2:0] MODE_TOP  = 3'd0;
  localparam logic [2:0] MODE_SS2  = 3'd1;
  localparam logic [2:0] MODE_A1DF = 3'd2;
  localparam logic [2:0] MODE_KANA = 3'd3;
  localparam logic [2:0] MODE_E0EF = 3'd4;

  localparam logic [7:0] PAIR_LEAD  = 8'ha4;
  localparam logic [7:0] SS2_BYTE   = 8'h8e;
  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] DEL_BYTE   = 8'h7f;
  localparam logic [7:0] FF_BYTE    = 8'hff;
  localparam logic [7:0] CTRL_LIMIT = 8'd6;
  localparam logic [3:0] PAIR_LIMIT = 4'd6;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] pair_cnt;
    logic       first_pending;
    logic       verdict_given;
  } jeg_state_t;

  localparam jeg_state_t STATE_RESET = '{
    mode:          MODE_TOP,
    pair_cnt:      3'd0,
    first_pending: 1'b1,
    verdict_given: 1'b0
  };

  function automatic logic in_rng(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

// ----- sv/jeg_classifier.sv -----
module jeg_classifier import jeg_pkg::*; (
  input  jeg_state_t cur_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  output jeg_state_t nxt_o,
  output logic       res_valid_o,
  output logic [2:0] verdict_o
);

  logic [3:0] pc;
  logic       sjis_lead;
  logic       cls_hit;
  logic [2:0] cls_verdict;
  logic [2:0] cls_mode;
  logic       ctr_euc;
  logic [7:0] b;

  assign b = data_byte_i;
  assign sjis_lead = in_rng(b, 8'h81, 8'h8d) || in_rng(b, 8'h8f, 8'h9f);

  // Byte classification in the current scan mode
  always_comb begin
    cls_hit     = 1'b0;
    cls_verdict = VERDICT_UNKNOWN;
    cls_mode    = MODE_TOP;
    case (cur_i.mode)
      MODE_SS2: begin
        if (in_rng(b, 8'h40, 8'h7e) || in_rng(b, 8'h80, 8'ha0) || in_rng(b, 8'he0, 8'hfc)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_SJIS;
        end
      end
      MODE_A1DF: begin
        if (in_rng(b, 8'hf0, 8'hfe)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_EUC;
        end else if (in_rng(b, 8'he0, 8'hef)) begin
          cls_mode = MODE_KANA;
        end else if (b <= 8'h9f) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_SJIS;
        end
      end
      MODE_KANA: begin
        cls_mode = MODE_KANA;
        if (b < 8'h40) begin
          cls_mode = MODE_TOP;
        end else if (sjis_lead) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_SJIS;
        end else if (in_rng(b, 8'hfd, 8'hfe)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_EUC;
        end
      end
      MODE_E0EF: begin
        if (in_rng(b, 8'h40, 8'h7e) || in_rng(b, 8'h80, 8'ha0)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_SJIS;
        end else if (in_rng(b, 8'hfd, 8'hfe)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_EUC;
        end
      end
      default: begin
        // top level; unused codes behave the same
        if (b == ESC_BYTE) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_JIS;
        end else if (b < CTRL_LIMIT || b == DEL_BYTE || b == FF_BYTE) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_BINARY;
        end else if (sjis_lead) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_SJIS;
        end else if (b == SS2_BYTE) begin
          cls_mode = MODE_SS2;
        end else if (in_rng(b, 8'ha1, 8'hdf)) begin
          cls_mode = MODE_A1DF;
        end else if (in_rng(b, 8'hf0, 8'hfe)) begin
          cls_hit     = 1'b1;
          cls_verdict = VERDICT_EUC;
        end else if (in_rng(b, 8'he0, 8'hef)) begin
          cls_mode = MODE_E0EF;
        end
      end
    endcase
  end

  // Pair counter: odd positions must be 0xa4, six in a row calls EUC
  always_comb begin
    pc = {1'b0, cur_i.pair_cnt} + 4'd1;
    if (pc[0] && (b != PAIR_LEAD)) begin
      pc = 4'd0;
    end
    ctr_euc = (pc >= PAIR_LIMIT);
    if (ctr_euc) begin
      pc = 4'd0;
    end
  end

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    verdict_o   = VERDICT_UNKNOWN;
    if (byte_present_i && !cur_i.verdict_given) begin
      if (cur_i.first_pending) begin
        nxt_o.pair_cnt      = (b == PAIR_LEAD) ? 3'd1 : 3'd0;
        nxt_o.first_pending = 1'b0;
      end else begin
        nxt_o.pair_cnt = pc[2:0];
      end
      if (!cur_i.first_pending && ctr_euc) begin
        res_valid_o = 1'b1;
        verdict_o   = VERDICT_EUC;
      end else begin
        nxt_o.mode  = cls_mode;
        res_valid_o = cls_hit;
        verdict_o   = cls_verdict;
      end
      nxt_o.verdict_given = res_valid_o;
    end
    if (end_of_text_i) begin
      if (!nxt_o.verdict_given) begin
        res_valid_o = 1'b1;
        verdict_o   = VERDICT_UNKNOWN;
      end
      nxt_o = STATE_RESET;
    end
  end

endmodule

// ----- sv/jeg_out_buf.sv -----
module jeg_out_buf import jeg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [2:0] push_verdict_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] verdict_o
);

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  logic [2:0] out_q, out_d;
  logic [2:0] skid_q, skid_d;
  logic       pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no push can arrive while the skid slot is occupied
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_verdict_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_verdict_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_q;

endmodule

// ----- sv/japanese_encoding_guesser.sv -----
// Guesses the Japanese encoding of a byte stream: one item per text byte, the
// last marked by end_of_text_i (an item with byte_present_i low ends an empty
// text). At most one verdict comes out per text: JIS, EUC, SJIS or binary
// as soon as a byte settles it, or unknown on the end item of an undecided text.
// Bytes after a verdict are dropped. One item is taken every cycle while in_stall_o
// is low; each item is held in the input register, and its verdict is then
// registered in the output buffer. A two-entry output buffer absorbs stalls, and
// in_stall_o rises only when both entries are full and an item is waiting.
module japanese_encoding_guesser import jeg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] verdict_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       present_q;
  logic       eot_q;
  jeg_state_t state_q, state_d;
  logic       res_valid;
  logic [2:0] res_verdict;
  logic       buf_full;
  logic       fire;
  logic       accept;

  assign fire       = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= STATE_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q    <= data_byte_i;
      present_q <= byte_present_i;
      eot_q     <= end_of_text_i;
    end
  end

  jeg_classifier u_classifier (
    .cur_i          (state_q),
    .data_byte_i    (byte_q),
    .byte_present_i (present_q),
    .end_of_text_i  (eot_q),
    .nxt_o          (state_d),
    .res_valid_o    (res_valid),
    .verdict_o      (res_verdict)
  );

  jeg_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (fire && res_valid),
    .push_verdict_i (res_verdict),
    .full_o         (buf_full),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o)
  );

endmodule

// ----- sv/jeg_checker.sv -----
`include "japanese_encoding_guesser_macros.svh"

module jeg_checker import jeg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       byte_present_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] verdict_o
);

  `JEG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(verdict_o), "stalled verdict changed")
  `JEG_ASSERT_NOW(a_verdict_code, out_valid_o, verdict_o <= VERDICT_BINARY, "verdict code out of range")
  `JEG_ASSERT_NOW(a_stall_needs_out, in_stall_o, out_valid_o, "input stalled with empty output")
  `JEG_ASSERT_NEXT(a_pop_frees_input, out_valid_o && !out_stall_i, !in_stall_o, "input stalled after output drained")

endmodule

bind japanese_encoding_guesser jeg_checker u_jeg_checker (.*);

// ----- tb/jeg_verdict_checker.sv -----
`timescale 1ns / 1ps

module jeg_verdict_checker import jeg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] verdict_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         examined_o
);

  jeg_state_t guess_st = STATE_RESET;
  logic [2:0] expected_verdicts[$];
  int         fails = 0;
  int         examined = 0;
  logic       step_hit;
  logic [2:0] step_verdict;
  logic [2:0] want;

  assign fail_count_o = fails;
  assign examined_o   = examined;

  function automatic logic in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic sjis_lead(logic [7:0] b);
    return in_span(b, 8'h81, 8'h8d) || in_span(b, 8'h8f, 8'h9f);
  endfunction

  // Classify one byte in the given scan mode; hit low means still undecided.
  function automatic void classify_byte(input logic [7:0] b, input logic [2:0] mode_in,
                                        output logic [2:0] mode_out, output logic hit,
                                        output logic [2:0] v);
    hit      = 1'b1;
    v        = VERDICT_UNKNOWN;
    mode_out = MODE_TOP;
    case (mode_in)
      MODE_SS2: begin
        hit = in_span(b, 8'h40, 8'h7e) || in_span(b, 8'h80, 8'ha0) ||
              in_span(b, 8'he0, 8'hfc);
        v   = VERDICT_SJIS;
      end
      MODE_A1DF: begin
        if (in_span(b, 8'hf0, 8'hfe)) v = VERDICT_EUC;
        else if (in_span(b, 8'he0, 8'hef)) begin
          mode_out = MODE_KANA;
          hit      = 1'b0;
        end else if (b <= 8'h9f) v = VERDICT_SJIS;
        else hit = 1'b0;
      end
      MODE_KANA: begin
        mode_out = MODE_KANA;
        if (b < 8'h40) begin
          mode_out = MODE_TOP;
          hit      = 1'b0;
        end else if (sjis_lead(b)) v = VERDICT_SJIS;
        else if (in_span(b, 8'hfd, 8'hfe)) v = VERDICT_EUC;
        else hit = 1'b0;
      end
      MODE_E0EF: begin
        if (in_span(b, 8'h40, 8'h7e) || in_span(b, 8'h80, 8'ha0)) v = VERDICT_SJIS;
        else if (in_span(b, 8'hfd, 8'hfe)) v = VERDICT_EUC;
        else hit = 1'b0;
      end
      default: begin
        if (b == ESC_BYTE) v = VERDICT_JIS;
        else if (b < CTRL_LIMIT || b == DEL_BYTE || b == FF_BYTE) v = VERDICT_BINARY;
        else if (sjis_lead(b)) v = VERDICT_SJIS;
        else if (b == SS2_BYTE) begin
          mode_out = MODE_SS2;
          hit      = 1'b0;
        end else if (in_span(b, 8'ha1, 8'hdf)) begin
          mode_out = MODE_A1DF;
          hit      = 1'b0;
        end else if (in_span(b, 8'hf0, 8'hfe)) v = VERDICT_EUC;
        else if (in_span(b, 8'he0, 8'hef)) begin
          mode_out = MODE_E0EF;
          hit      = 1'b0;
        end else hit = 1'b0;
      end
    endcase
  endfunction

  // Advance the guesser by one item.
  function automatic void predict_verdict(input logic [7:0] b, input logic present,
                                          input logic last, output logic hit,
                                          output logic [2:0] v);
    logic [3:0] pc;
    logic [2:0] next_mode;
    logic       pair_euc;
    hit      = 1'b0;
    v        = VERDICT_UNKNOWN;
    pair_euc = 1'b0;
    if (present && !guess_st.verdict_given) begin
      if (guess_st.first_pending) begin
        guess_st.pair_cnt      = (b == PAIR_LEAD) ? 3'd1 : 3'd0;
        guess_st.first_pending = 1'b0;
      end else begin
        pc = {1'b0, guess_st.pair_cnt} + 4'd1;
        if (pc[0] && b != PAIR_LEAD) pc = 4'd0;
        if (pc >= PAIR_LIMIT) begin
          pc       = 4'd0;
          pair_euc = 1'b1;
        end
        guess_st.pair_cnt = pc[2:0];
      end
      if (pair_euc) begin
        hit = 1'b1;
        v   = VERDICT_EUC;
      end else begin
        classify_byte(b, guess_st.mode, next_mode, hit, v);
        guess_st.mode = next_mode;
      end
      if (hit) guess_st.verdict_given = 1'b1;
    end
    if (last) begin
      if (!guess_st.verdict_given) begin
        hit = 1'b1;
        v   = VERDICT_UNKNOWN;
      end
      guess_st = STATE_RESET;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guess_st = STATE_RESET;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict: expected none, actual %0d", verdict_i);
          fails++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_i !== want) begin
            $error("verdict: expected %0d, actual %0d", want, verdict_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_verdict(data_byte_i, byte_present_i, end_of_text_i,
                        step_hit, step_verdict);
        if (step_hit) expected_verdicts.push_back(step_verdict);
        examined++;
      end
    end
    pending_o = expected_verdicts.size();
  end

endmodule

// ----- tb/tb_japanese_encoding_guesser.sv -----
`timescale 1ns / 1ps

module tb_japanese_encoding_guesser;
  import jeg_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       byte_present_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] verdict_o;

  int fails;
  int pending;
  int examined;
  int sender_idle_pct = 34;
  int recv_stall_pct  = 76;
  int hold_req        = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;
  logic [7:0] text_bytes[$];

  always #1 clk_i = ~clk_i;

  japanese_encoding_guesser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o)
  );

  jeg_verdict_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_i      (verdict_o),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .examined_o     (examined)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    byte_present_i <= present;
    end_of_text_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic noisy);
    logic absent_end;
    absent_end = noisy && ($urandom_range(7) == 0);
    if (text_bytes.size() == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      foreach (text_bytes[i]) begin
        if (noisy && $urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        send_item(text_bytes[i], 1'b1, !absent_end && (i == text_bytes.size() - 1));
      end
      if (absent_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  // Mostly well-formed multibyte runs behind a short ASCII prefix, plus noise.
  task automatic make_text();
    int kind;
    text_bytes.delete();
    kind = $urandom_range(9);
    repeat ($urandom_range(4)) text_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
    case (kind)
      0: repeat ($urandom_range(8, 1)) text_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
      1: repeat ($urandom_range(4, 1)) begin
        text_bytes.push_back(8'($urandom_range(8'hfe, 8'ha1)));
        text_bytes.push_back(8'($urandom_range(8'hfe, 8'ha1)));
      end
      2: repeat ($urandom_range(4, 2)) begin
        text_bytes.push_back(PAIR_LEAD);
        text_bytes.push_back(8'($urandom_range(8'hdf, 8'ha1)));
      end
      3: repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(1)) text_bytes.push_back(8'($urandom_range(8'h9f, 8'h81)));
        else text_bytes.push_back(8'($urandom_range(8'hfc, 8'he0)));
        text_bytes.push_back(8'($urandom_range(8'hfc, 8'h40)));
      end
      4: begin
        repeat ($urandom_range(3, 1)) text_bytes.push_back(8'($urandom_range(8'hdf, 8'ha1)));
        text_bytes.push_back(8'($urandom_range(8'hef, 8'he0)));
        repeat ($urandom_range(3, 1)) text_bytes.push_back(8'($urandom_range(255)));
      end
      5: begin
        text_bytes.push_back(ESC_BYTE);
        text_bytes.push_back(8'h24);
        text_bytes.push_back(8'h42);
      end
      6, 7: repeat ($urandom_range(6, 1)) text_bytes.push_back(8'($urandom_range(255)));
      8: begin
        text_bytes.push_back(SS2_BYTE);
        text_bytes.push_back(8'($urandom_range(255)));
      end
      default: text_bytes.delete();
    endcase
  endtask

  // Receiver: random stall, with one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int base;
    int phase;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    byte_present_i = 1'b0;
    end_of_text_i  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty text, JIS and binary classes, each mode, pair counter, ignored bytes.
    text_bytes = {};                                     send_text(1'b0);
    text_bytes = {ESC_BYTE};                             send_text(1'b0);
    text_bytes = {8'h00};                                send_text(1'b0);
    text_bytes = {8'h06, FF_BYTE};                       send_text(1'b0);
    text_bytes = {SS2_BYTE, 8'h40};                      send_text(1'b0);
    text_bytes = {8'ha1, 8'hf0};                         send_text(1'b0);
    text_bytes = {8'ha1, 8'he0, 8'h30, 8'h41};           send_text(1'b0);
    text_bytes = {8'hb0, 8'he5, 8'h9f};                  send_text(1'b0);
    text_bytes = {8'he0, 8'hfd};                         send_text(1'b0);
    text_bytes = {PAIR_LEAD, 8'ha2, PAIR_LEAD, 8'ha2, PAIR_LEAD, 8'ha2, 8'h41};
    send_text(1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    text_bytes = {8'h41};                                send_text(1'b0);

    base  = examined;
    phase = 0;
    while (examined - base < RANDOM_ITEMS) begin
      if (phase == 0 && examined - base >= RANDOM_ITEMS / 3) begin
        phase           = 1;
        sender_idle_pct = 76;
        recv_stall_pct  = 34;
      end else if (phase == 1 && examined - base >= 2 * RANDOM_ITEMS / 3) begin
        // Full rate from here, starting with a long receiver hold-off.
        phase           = 2;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req        = 1;
      end
      make_text();
      send_text(1'b1);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
